// ===== sv/ecd_pkg.sv =====
`default_nettype none

package ecd_pkg;

  // Field and register widths
  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 17;
  localparam int FB_W      = 15;
  localparam int MIX_W     = 16;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  // Accumulator for the Q1.15 product sums
  localparam int ACC_W = 34;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS   = 2'd3;

  // Register reset values
  localparam logic [DELAY_W-1:0] DELAY_RST    = 17'd24000;
  localparam logic [FB_W-1:0]    FEEDBACK_RST = 15'd16384;
  localparam logic [MIX_W-1:0]   MIX_RST      = 16'd16384;

  // Unity gain in Q1.15
  localparam logic [MIX_W-1:0] Q15_ONE = 16'h8000;

  // Output queue
  localparam int QDEPTH = 8;
  localparam int QPTR_W = 3;
  localparam int QCNT_W = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Per-word control carried down the pipeline
  typedef struct packed {
    logic    valid;
    logic    active;
    logic    channel;
    sample_t x;
  } pipe_ctl_t;

  typedef struct packed {
    sample_t sample_out;
    logic    channel_out;
  } out_word_t;

  localparam logic signed [ACC_W-1:0] ACC_HALF = 34'sd16384;
  localparam logic signed [ACC_W-1:0] ACC_SMAX = 34'sd32767;
  localparam logic signed [ACC_W-1:0] ACC_SMIN = -34'sd32768;

  // Round half up of acc / 32768, then clip to the sample range
  function automatic sample_t sat_q15(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    sample_t                 s;
    r = (acc + ACC_HALF) >>> 15;
    if (r > ACC_SMAX) begin
      s = sample_t'(ACC_SMAX[SAMPLE_W-1:0]);
    end else if (r < ACC_SMIN) begin
      s = sample_t'(ACC_SMIN[SAMPLE_W-1:0]);
    end else begin
      s = sample_t'(r[SAMPLE_W-1:0]);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ecd_stream_if.sv =====
`default_nettype none

// Input word: one sample tagged with its channel
interface ecd_in_if;
  logic             valid;
  logic             ready;
  ecd_pkg::sample_t sample_in;
  logic             channel;

  modport source (output valid, output sample_in, output channel, input ready);
  modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

// Output word: mixed sample and its channel
interface ecd_out_if;
  logic             valid;
  logic             ready;
  ecd_pkg::sample_t sample_out;
  logic             channel_out;

  modport source (output valid, output sample_out, output channel_out, input ready);
  modport sink   (input valid, input sample_out, input channel_out, output ready);
endinterface

`default_nettype wire

// ===== sv/ecd_ring_mem.sv =====
`default_nettype none

module ecd_ring_mem #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                raddr,
  output logic      [ecd_pkg::SAMPLE_W-1:0] rdata,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [ecd_pkg::SAMPLE_W-1:0] wdata
);
  import ecd_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // Read-first: a read at the write address returns the old word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ecd_mix.sv =====
`default_nettype none

// Gain products (registered) and the rounded, clipped sums behind them
module ecd_mix (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ecd_pkg::pipe_ctl_t           ctl_in,
  input  wire ecd_pkg::sample_t             delayed,
  input  wire logic [ecd_pkg::FB_W-1:0]     feedback_gain,
  input  wire logic [ecd_pkg::MIX_W-1:0]    mix,
  output ecd_pkg::pipe_ctl_t                ctl_out,
  output ecd_pkg::sample_t                  fb_sample,
  output ecd_pkg::sample_t                  mix_sample
);
  import ecd_pkg::*;

  logic [MIX_W-1:0]          dry;
  logic signed [31:0]        p_fb;
  logic signed [32:0]        p_dry;
  logic signed [32:0]        p_wet;
  logic signed [ACC_W-1:0]   acc_fb;
  logic signed [ACC_W-1:0]   acc_mix;

  // mix is at most unity, so the dry gain fits
  assign dry = Q15_ONE - mix;

  // Products
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.active  <= ctl_in.active;
    ctl_out.channel <= ctl_in.channel;
    ctl_out.x       <= ctl_in.x;
    p_fb            <= delayed * $signed({1'b0, feedback_gain});
    p_dry           <= ctl_in.x * $signed({1'b0, dry});
    p_wet           <= delayed * $signed({1'b0, mix});
  end

  // Sums, rounding and clipping
  always_comb begin
    acc_fb     = (ACC_W'(ctl_out.x) <<< 15) + ACC_W'(p_fb);
    acc_mix    = ACC_W'(p_dry) + ACC_W'(p_wet);
    fb_sample  = sat_q15(acc_fb);
    mix_sample = sat_q15(acc_mix);
  end

endmodule

`default_nettype wire

// ===== sv/ecd_out_fifo.sv =====
`default_nettype none

// Output queue; upstream credit keeps it from overflowing
module ecd_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire ecd_pkg::out_word_t  push_word,
  ecd_out_if.source                out_ch
);
  import ecd_pkg::*;

  out_word_t           q [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;

  assign pop                = out_ch.valid && out_ch.ready;
  assign out_ch.valid       = (count != '0);
  assign out_ch.sample_out  = q[rptr].sample_out;
  assign out_ch.channel_out = q[rptr].channel_out;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= push_word;
    end
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/feedback_delay_echo.sv =====
`default_nettype none

// Channel   Dir  Payload                     Handshake
// in_ch     in   sample_in[15:0], channel    valid/ready
// out_ch    out  sample_out[15:0], channel_out valid/ready
// cfg       in   cfg_index[1:0], cfg_data    cfg_we, no wait
//
// One word per cycle while in_ch.ready is high; a result is offered once its
// word has passed the pipeline stages and been pushed into the output queue.
// With a delay of one sample, a word directly after an active word is held back:
// its ring read would hit a write still in the product stage.
// Reset clears the write positions and per-channel wrap flags; unwritten
// ring entries read as zero from those flags, so there is no clearing pass.
// Up to 8 words in flight; the 8-entry output queue absorbs downstream stalls.
module feedback_delay_echo #(
  parameter int MAX_DELAY    = 131072,
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ecd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ecd_pkg::CFG_W-1:0]     cfg_data,
  ecd_in_if.sink                             in_ch,
  ecd_out_if.source                          out_ch
);
  import ecd_pkg::*;

  localparam int PW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DEPTH = NUM_CHANNELS * MAX_DELAY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [31:0] DMAX = 32'(MAX_DELAY - 1);

  // Configuration
  logic [DELAY_W-1:0] delay_samples;
  logic [FB_W-1:0]    feedback_gain;
  logic [MIX_W-1:0]   wet_mix;
  logic               bypass;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= DELAY_RST;
      feedback_gain <= FEEDBACK_RST;
      wet_mix       <= MIX_RST;
      bypass        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY:    delay_samples <= cfg_data[DELAY_W-1:0];
        REG_FEEDBACK: feedback_gain <= cfg_data[FB_W-1:0];
        REG_MIX:      wet_mix       <= cfg_data[MIX_W-1:0];
        REG_BYPASS:   bypass        <= cfg_data[0];
        default:      bypass        <= bypass;
      endcase
    end
  end

  // Clamped delay and mix
  logic [31:0]      d_ext;
  logic [31:0]      d_clamp;
  logic [PW-1:0]    d_eff;
  logic [MIX_W-1:0] mix_eff;

  always_comb begin
    d_ext = 32'(delay_samples);
    if (d_ext == 32'd0) begin
      d_clamp = 32'd1;
    end else if (d_ext > DMAX) begin
      d_clamp = DMAX;
    end else begin
      d_clamp = d_ext;
    end
    d_eff   = d_clamp[PW-1:0];
    mix_eff = (wet_mix > Q15_ONE) ? Q15_ONE : wet_mix;
  end

  // Pipeline registers
  pipe_ctl_t      s1_ctl;
  logic [AW-1:0]  s1_raddr;
  logic [AW-1:0]  s1_waddr;
  logic           s1_ok;
  pipe_ctl_t      s2_ctl;
  sample_t        s2_delayed;
  logic [AW-1:0]  s2_waddr;
  pipe_ctl_t      s3_ctl;
  logic [AW-1:0]  s3_waddr;

  // Last ring write, for reads issued on the same edge
  logic           lw_valid;
  logic [AW-1:0]  lw_addr;
  sample_t        lw_data;

  // Write positions and wrap flags
  logic [PW-1:0]           wp [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] wrapped;

  // Credit for the output queue
  logic [QCNT_W-1:0] inflight;

  logic           in_fire;
  logic           out_fire;
  logic           in_active;
  logic [CW-1:0]  ch_idx;
  logic [PW-1:0]  wp_cur;
  logic [PW-1:0]  wp_next;
  logic [PW-1:0]  rd_pos;
  logic [AW-1:0]  ch_base;
  logic           entry_ok;
  logic           hazard;

  assign in_active = !bypass && (32'(in_ch.channel) < 32'(NUM_CHANNELS));
  assign ch_idx    = in_active ? CW'(in_ch.channel) : '0;
  assign wp_cur    = wp[ch_idx];
  assign hazard    = s1_ctl.valid && s1_ctl.active && (d_eff == PW'(1));
  assign in_ch.ready = (inflight < QCNT_W'(QDEPTH)) && !hazard;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_ch.valid && out_ch.ready;

  // Ring addressing for the incoming word
  always_comb begin
    if (wp_cur >= d_eff) begin
      rd_pos = wp_cur - d_eff;
    end else begin
      rd_pos = wp_cur + (PW'(MAX_DELAY) - d_eff);
    end
    wp_next  = (wp_cur == PW'(MAX_DELAY - 1)) ? '0 : wp_cur + 1'b1;
    ch_base  = AW'(32'(ch_idx) * 32'(MAX_DELAY));
    entry_ok = wrapped[ch_idx] || (rd_pos < wp_cur);
  end

  // Write position update on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wp[i] <= '0;
      end
      wrapped <= '0;
    end else if (in_fire && in_active) begin
      wp[ch_idx] <= wp_next;
      if (wp_cur == PW'(MAX_DELAY - 1)) begin
        wrapped[ch_idx] <= 1'b1;
      end
    end
  end

  // Words between acceptance and delivery
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({in_fire, out_fire})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  // Ring memory
  logic [SAMPLE_W-1:0] rdata;
  logic                mem_we;
  sample_t             fb_sample;
  sample_t             mix_sample;

  assign mem_we = s3_ctl.valid && s3_ctl.active;

  ecd_ring_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .rd_en (in_fire),
    .raddr (ch_base + AW'(rd_pos)),
    .rdata (rdata),
    .we    (mem_we),
    .waddr (s3_waddr),
    .wdata (fb_sample)
  );

  // Stage 1: read issued
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else begin
      s1_ctl.valid <= in_fire;
    end
    s1_ctl.active  <= in_active;
    s1_ctl.channel <= in_ch.channel;
    s1_ctl.x       <= in_ch.sample_in;
    s1_raddr       <= ch_base + AW'(rd_pos);
    s1_waddr       <= ch_base + AW'(wp_cur);
    s1_ok          <= entry_ok;
  end

  // Delayed sample: forward pending writes, zero for unwritten entries
  sample_t delayed1;

  always_comb begin
    if (!s1_ok) begin
      delayed1 = '0;
    end else if (mem_we && (s3_waddr == s1_raddr)) begin
      delayed1 = fb_sample;
    end else if (lw_valid && (lw_addr == s1_raddr)) begin
      delayed1 = lw_data;
    end else begin
      delayed1 = sample_t'(rdata);
    end
  end

  // Stage 2: delayed sample resolved
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl.valid <= 1'b0;
    end else begin
      s2_ctl.valid <= s1_ctl.valid;
    end
    s2_ctl.active  <= s1_ctl.active;
    s2_ctl.channel <= s1_ctl.channel;
    s2_ctl.x       <= s1_ctl.x;
    s2_delayed     <= delayed1;
    s2_waddr       <= s1_waddr;
  end

  // Stage 3: products, then sums
  ecd_mix u_mix (
    .clk           (clk),
    .rst           (rst),
    .ctl_in        (s2_ctl),
    .delayed       (s2_delayed),
    .feedback_gain (feedback_gain),
    .mix           (mix_eff),
    .ctl_out       (s3_ctl),
    .fb_sample     (fb_sample),
    .mix_sample    (mix_sample)
  );

  always_ff @(posedge clk) begin
    s3_waddr <= s2_waddr;
  end

  // Last write record
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else begin
      lw_valid <= mem_we;
    end
    lw_addr <= s3_waddr;
    lw_data <= fb_sample;
  end

  // Result word into the output queue
  out_word_t res_word;

  always_comb begin
    res_word.sample_out  = s3_ctl.active ? mix_sample : s3_ctl.x;
    res_word.channel_out = s3_ctl.channel;
  end

  ecd_out_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_ctl.valid),
    .push_word (res_word),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
